// ===== sv/capf_pkg.sv =====
// ============================================================================
// capf_pkg
// Shared types and constants for the circular aperture flux block.
// ============================================================================
package capf_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int POS_BITS   = COORD_BITS + FRAC_BITS;
  localparam int SQ_BITS    = 2 * POS_BITS;
  localparam int DIM_BITS   = 13;
  localparam int CFG_BITS   = 20;
  localparam int IDX_BITS   = 3;
  localparam int VAL_BITS   = 24;
  localparam int ERR_BITS   = 16;
  localparam int ESQ_IN_BITS = 2 * ERR_BITS;
  localparam int FLUX_BITS  = 48;
  localparam int CNT_BITS   = 25;
  localparam int ESQ_BITS   = 56;
  localparam int ROOT_BITS  = ESQ_BITS / 2;
  localparam int REM_BITS   = ROOT_BITS + 4;
  localparam int ROOT_STEPS = ROOT_BITS;
  localparam int STEP_BITS  = $clog2(ROOT_STEPS);

  // Configuration register indexes.
  localparam logic [IDX_BITS-1:0] CFG_CENTER_X     = 3'd0;
  localparam logic [IDX_BITS-1:0] CFG_CENTER_Y     = 3'd1;
  localparam logic [IDX_BITS-1:0] CFG_RADIUS       = 3'd2;
  localparam logic [IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 3'd3;
  localparam logic [IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 3'd4;

  localparam logic [DIM_BITS-1:0] DIM_RESET = 13'd4096;

  typedef struct packed {
    logic [COORD_BITS-1:0]      column;
    logic [COORD_BITS-1:0]      row;
    logic signed [VAL_BITS-1:0] pixel_value;
    logic [ERR_BITS-1:0]        pixel_error;
    logic                       last_pixel;
  } capf_in_t;

  typedef struct packed {
    logic signed [FLUX_BITS-1:0] flux_sum;
    logic [CNT_BITS-1:0]         pixel_count;
    logic [ROOT_BITS-1:0]        error_flux;
  } capf_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic root_step;
  } capf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic snap;
  } capf_sts_t;

endpackage

// ===== sv/capf_dp.sv =====
// ============================================================================
// capf_dp
// Datapath: configuration registers, aperture test pipeline, accumulators
// and a digit-by-digit square root unit.
// ============================================================================
module capf_dp import capf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  capf_in_t             in_data,
  input  logic                 cfg_we,
  input  logic [IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_wdata,
  input  capf_cmd_t            cmd,
  output capf_sts_t            sts,
  output capf_out_t            out_data
);

  logic [POS_BITS-1:0]  cx_r, cy_r, radius_r;
  logic [DIM_BITS-1:0]  width_r, height_r;
  logic [SQ_BITS-1:0]   rsq_r;

  logic                 s1_vld_r, s1_in_r, s1_last_r;
  logic [POS_BITS-1:0]  s1_dx_r, s1_dy_r;
  logic [VAL_BITS-1:0]  s1_val_r;
  logic [ERR_BITS-1:0]  s1_err_r;

  logic                 s2_vld_r, s2_in_r, s2_last_r;
  logic [SQ_BITS-1:0]   s2_dxsq_r, s2_dysq_r;
  logic [VAL_BITS-1:0]  s2_val_r;
  logic [ESQ_IN_BITS-1:0] s2_esq_r;

  logic [FLUX_BITS-1:0] flux_acc_r, flux_acc_nxt, flux_inc;
  logic [CNT_BITS-1:0]  cnt_acc_r, cnt_acc_nxt, cnt_inc;
  logic [ESQ_BITS-1:0]  esq_acc_r, esq_acc_nxt, esq_inc;

  logic [FLUX_BITS-1:0] flux_out_r;
  logic [CNT_BITS-1:0]  cnt_out_r;
  logic [ESQ_BITS-1:0]  rad_sh_r, rad_sh_nxt;
  logic [REM_BITS-1:0]  rem_r, rem_nxt, rem_sh, trial;
  logic [ROOT_BITS-1:0] root_r, root_nxt;

  logic [POS_BITS-1:0]  pos_x, pos_y, dx, dy;
  logic                 in_img;
  logic [SQ_BITS:0]     dist_sq;
  logic                 hit, snap, ge;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      radius_r <= '0;
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X:     cx_r     <= cfg_wdata[POS_BITS-1:0];
        CFG_CENTER_Y:     cy_r     <= cfg_wdata[POS_BITS-1:0];
        CFG_RADIUS:       radius_r <= cfg_wdata[POS_BITS-1:0];
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[DIM_BITS-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rsq_r <= SQ_BITS'(radius_r) * SQ_BITS'(radius_r);
  end

  // Stage 1: distances from the centre and the image bounds test.
  always_comb begin
    pos_x  = POS_BITS'(in_data.column) << FRAC_BITS;
    pos_y  = POS_BITS'(in_data.row) << FRAC_BITS;
    dx     = (pos_x >= cx_r) ? (pos_x - cx_r) : (cx_r - pos_x);
    dy     = (pos_y >= cy_r) ? (pos_y - cy_r) : (cy_r - pos_y);
    in_img = (DIM_BITS'(in_data.column) < width_r) &&
             (DIM_BITS'(in_data.row) < height_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.accept;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_dx_r   <= dx;
    s1_dy_r   <= dy;
    s1_in_r   <= in_img;
    s1_last_r <= in_data.last_pixel;
    s1_val_r  <= in_data.pixel_value;
    s1_err_r  <= in_data.pixel_error;
    // Stage 2: squares.
    s2_dxsq_r <= SQ_BITS'(s1_dx_r) * SQ_BITS'(s1_dx_r);
    s2_dysq_r <= SQ_BITS'(s1_dy_r) * SQ_BITS'(s1_dy_r);
    s2_esq_r  <= ESQ_IN_BITS'(s1_err_r) * ESQ_IN_BITS'(s1_err_r);
    s2_in_r   <= s1_in_r;
    s2_last_r <= s1_last_r;
    s2_val_r  <= s1_val_r;
  end

  // Stage 3: radius compare and accumulation.
  always_comb begin
    dist_sq  = {1'b0, s2_dxsq_r} + {1'b0, s2_dysq_r};
    hit      = s2_in_r && (dist_sq <= {1'b0, rsq_r});
    snap     = s2_vld_r && s2_last_r;
    flux_inc = flux_acc_r;
    cnt_inc  = cnt_acc_r;
    esq_inc  = esq_acc_r;
    if (hit) begin
      flux_inc = flux_acc_r +
                 {{(FLUX_BITS-VAL_BITS){s2_val_r[VAL_BITS-1]}}, s2_val_r};
      cnt_inc  = cnt_acc_r + CNT_BITS'(1);
      esq_inc  = esq_acc_r + ESQ_BITS'(s2_esq_r);
    end
    if (snap) begin
      flux_acc_nxt = '0;
      cnt_acc_nxt  = '0;
      esq_acc_nxt  = '0;
    end else if (s2_vld_r) begin
      flux_acc_nxt = flux_inc;
      cnt_acc_nxt  = cnt_inc;
      esq_acc_nxt  = esq_inc;
    end else begin
      flux_acc_nxt = flux_acc_r;
      cnt_acc_nxt  = cnt_acc_r;
      esq_acc_nxt  = esq_acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flux_acc_r <= '0;
      cnt_acc_r  <= '0;
      esq_acc_r  <= '0;
    end else begin
      flux_acc_r <= flux_acc_nxt;
      cnt_acc_r  <= cnt_acc_nxt;
      esq_acc_r  <= esq_acc_nxt;
    end
  end

  // Square root: two radicand bits per step, one result bit per step.
  always_comb begin
    rem_sh     = {rem_r[REM_BITS-3:0], rad_sh_r[ESQ_BITS-1 -: 2]};
    trial      = REM_BITS'({root_r, 2'b01});
    ge         = (rem_sh >= trial);
    rem_nxt    = ge ? (rem_sh - trial) : rem_sh;
    root_nxt   = {root_r[ROOT_BITS-2:0], ge};
    rad_sh_nxt = rad_sh_r << 2;
  end

  always_ff @(posedge clk) begin
    if (snap) begin
      flux_out_r <= flux_inc;
      cnt_out_r  <= cnt_inc;
      rad_sh_r   <= esq_inc;
      rem_r      <= '0;
      root_r     <= '0;
    end else if (cmd.root_step) begin
      rad_sh_r <= rad_sh_nxt;
      rem_r    <= rem_nxt;
      root_r   <= root_nxt;
    end
  end

  assign sts.snap             = snap;
  assign out_data.flux_sum    = flux_out_r;
  assign out_data.pixel_count = cnt_out_r;
  assign out_data.error_flux  = root_r;

endmodule

// ===== sv/capf_ctrl.sv =====
// ============================================================================
// capf_ctrl
// Controller: accepts items, waits for the frame's last item to reach the
// accumulators, sequences the square root and raises the result strobe.
// ============================================================================
module capf_ctrl import capf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       last_pixel,
  input  capf_sts_t  sts,
  output capf_cmd_t  cmd,
  output logic       busy,
  output logic       out_valid
);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    cmd.accept    = 1'b0;
    cmd.root_step = 1'b0;
    case (state_r)
      ST_RUN: begin
        cmd.accept = start;
        if (start && last_pixel) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts.snap) begin
          state_nxt = ST_ROOT;
          step_nxt  = '0;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        step_nxt      = step_r + STEP_BITS'(1);
        if (step_r == STEP_BITS'(ROOT_STEPS - 1)) begin
          state_nxt     = ST_RUN;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_RUN);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/circular_aperture_flux_with_error.sv =====
// ============================================================================
// circular_aperture_flux_with_error
// Circular aperture photometry over a pixel stream, with error propagation.
// ============================================================================
// How to use this block:
// Pixels enter on in_data; an item is taken at a rising edge where start is
// high and busy is low. A pixel counts when it lies inside the image and its
// integer position is within the configured radius of the configured center
// (all three in fixed point with eight fraction bits). Counted pixels add to
// a flux sum, a pixel count and a sum of squared errors.
// Pixels that are not the last of a frame are taken one per cycle, with no
// gaps. The item marked last_pixel makes busy rise; the result appears on
// out_data with out_valid high for exactly one cycle, and busy falls in that
// same cycle. The wait is set by a three-stage compare and accumulate
// pipeline followed by a square root unit that resolves one result bit per
// cycle until the whole root is found.
// The receiver cannot stall: the result must be captured in its strobe cycle.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata by the user while the block is idle; the block does not enforce
// this. Writes to unused indexes are dropped. Reset sets the center and
// radius to zero, the image size to 4096 by 4096 and clears all accumulators.
// ============================================================================
module circular_aperture_flux_with_error import capf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  capf_in_t            in_data,
  output logic                out_valid,
  output capf_out_t           out_data,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wdata
);

  // Commands and status between the sequencer and the arithmetic.
  capf_cmd_t cmd;
  capf_sts_t sts;

  // The controller owns the handshake and the square root step count.
  capf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .last_pixel (in_data.last_pixel),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid)
  );

  // The datapath holds configuration, the pipeline, the sums and the root.
  capf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// ===== sv/capf_chk.sv =====
// ============================================================================
// capf_chk
// Port-level checks on the frame handshake and result strobe.
// ============================================================================
module capf_chk import capf_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input capf_in_t in_data,
  input logic     out_valid
);

  // A frame's last item closes the input until its result is out.
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.last_pixel) |=> busy)
    else $error("last item accepted without raising busy");

  // A result comes only at the end of a busy period.
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a busy period");

  // Every busy period ends with a result.
  a_busy_ends: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // One result per frame: the strobe lasts a single cycle.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

endmodule

bind circular_aperture_flux_with_error capf_chk u_chk (.*);

// ===== verif/tb_circular_aperture_flux_with_error.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_circular_aperture_flux_with_error
// Self-checking bench for the circular aperture photometry block. Pixel items
// are driven from a queue in random bursts, and an item-level predictor works
// out the flux, count and error root of each frame. Every strobed result is
// compared field by field against the oldest predicted result.
// ============================================================================
module tb_circular_aperture_flux_with_error;
  import capf_pkg::*;

  // Cycles allowed for the compare and accumulate pipeline to empty before
  // the settings change. Items that close no frame give no sign of when they
  // are done, so this covers the pipeline with plenty of margin.
  localparam int DRAIN_CYCLES = 40;
  // Longest run of cycles with no item taken and no result seen.
  localparam int STALL_LIMIT = 2000;
  // Indexes with no register behind them; writes there must be dropped.
  localparam logic [IDX_BITS-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int RANDOM_PHASES = 7;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  capf_in_t            in_data = '0;
  logic                out_valid;
  capf_out_t           out_data;
  logic                cfg_we = 1'b0;
  logic [IDX_BITS-1:0] cfg_index = CFG_CENTER_X;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  circular_aperture_flux_with_error uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the aperture settings.
  logic [CFG_BITS-1:0] ap_center_x;
  logic [CFG_BITS-1:0] ap_center_y;
  logic [CFG_BITS-1:0] ap_radius;
  logic [DIM_BITS-1:0] ap_width;
  logic [DIM_BITS-1:0] ap_height;

  // Predictor copy of the frame accumulators.
  logic [FLUX_BITS-1:0] flux_acc;
  logic [CNT_BITS-1:0]  count_acc;
  logic [ESQ_BITS-1:0]  err_sq_acc;

  capf_in_t  pixel_queue[$];   // items waiting for the driver
  capf_out_t frame_results[$]; // predicted results, oldest first

  int mismatch_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Floor of the square root, found one result bit at a time from the top.
  function automatic logic [ROOT_BITS-1:0] floor_root(input logic [ESQ_BITS-1:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = ROOT_BITS - 1; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= {8'd0, v}) root = trial;
    end
    return root[ROOT_BITS-1:0];
  endfunction

  // Adds one accepted pixel to the predicted sums. The pixel position is
  // scaled up to the fixed point grid of the center, so the distance test is
  // exact. A pixel that closes a frame yields a result and clears the sums.
  task automatic fold_pixel(input capf_in_t px);
    logic [63:0] pos_x;
    logic [63:0] pos_y;
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] r;
    capf_out_t   res;
    if ({1'b0, px.column} < ap_width && {1'b0, px.row} < ap_height) begin
      pos_x = 64'(px.column) << FRAC_BITS;
      pos_y = 64'(px.row) << FRAC_BITS;
      dx = (pos_x >= 64'(ap_center_x)) ? pos_x - 64'(ap_center_x) : 64'(ap_center_x) - pos_x;
      dy = (pos_y >= 64'(ap_center_y)) ? pos_y - 64'(ap_center_y) : 64'(ap_center_y) - pos_y;
      r = 64'(ap_radius);
      if (dx * dx + dy * dy <= r * r) begin
        flux_acc = flux_acc +
                   {{(FLUX_BITS - VAL_BITS){px.pixel_value[VAL_BITS-1]}}, px.pixel_value};
        count_acc = count_acc + 1'b1;
        err_sq_acc = err_sq_acc + ESQ_BITS'(px.pixel_error) * ESQ_BITS'(px.pixel_error);
      end
    end
    if (px.last_pixel) begin
      res.flux_sum = flux_acc;
      res.pixel_count = count_acc;
      res.error_flux = floor_root(err_sq_acc);
      frame_results.push_back(res);
      flux_acc = '0;
      count_acc = '0;
      err_sq_acc = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Result check, pixel prediction and the stall watchdog share one clocked
  // block. Everything is sampled at the rising edge, so the values seen are
  // the ones the block itself acts on at that edge.
  always @(posedge clk) begin
    capf_out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (frame_results.size() == 0) begin
          report_mismatch("result with none expected", 64'(out_data.pixel_count), '0);
        end else begin
          want = frame_results.pop_front();
          if (out_data.flux_sum !== want.flux_sum)
            report_mismatch("flux_sum", 64'(out_data.flux_sum), 64'(want.flux_sum));
          if (out_data.pixel_count !== want.pixel_count)
            report_mismatch("pixel_count", 64'(out_data.pixel_count), 64'(want.pixel_count));
          if (out_data.error_flux !== want.error_flux)
            report_mismatch("error_flux", 64'(out_data.error_flux), 64'(want.error_flux));
        end
      end
      if (start && !busy) fold_pixel(in_data);

      if (out_valid || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles", STALL_LIMIT);
        $display("circular_aperture_flux_with_error verification failed");
        $finish;
      end
    end
  end

  // Driver. An item stays on in_data with start high until the block takes
  // it; busy holds it off while a frame result is being computed. Between
  // bursts of random length the driver leaves random gaps, and about one
  // burst in four is followed by no gap at all.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pixel_queue.size() == 0) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        in_data <= pixel_queue.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 60);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  function automatic capf_in_t make_pixel(input int col, input int row, input int val,
                                          input int err, input logic last);
    capf_in_t px;
    px.column = COORD_BITS'(col);
    px.row = COORD_BITS'(row);
    px.pixel_value = VAL_BITS'(val);
    px.pixel_error = ERR_BITS'(err);
    px.last_pixel = last;
    return px;
  endfunction

  // Random pixel: mostly aimed at the aperture so that a good share lands
  // inside the circle, the rest spread over the whole coordinate range.
  function automatic capf_in_t random_pixel(input logic last);
    capf_in_t px;
    int span;
    int col;
    int row;
    px.pixel_value = VAL_BITS'($urandom);
    px.pixel_error = ($urandom_range(0, 7) == 0) ? '1 : ERR_BITS'($urandom);
    px.last_pixel = last;
    if ($urandom_range(0, 3) == 0) begin
      px.column = COORD_BITS'($urandom);
      px.row = COORD_BITS'($urandom);
    end else begin
      span = int'(ap_radius >> FRAC_BITS) + 2;
      if (span > 64) span = 64;
      col = int'(ap_center_x >> FRAC_BITS) + int'($urandom_range(0, 2 * span)) - span;
      row = int'(ap_center_y >> FRAC_BITS) + int'($urandom_range(0, 2 * span)) - span;
      px.column = COORD_BITS'((col < 0) ? 0 : (col > 4095) ? 4095 : col);
      px.row = COORD_BITS'((row < 0) ? 0 : (row > 4095) ? 4095 : row);
    end
    return px;
  endfunction

  // Waits until every queued item is taken and every predicted result has
  // come, then lets the pipeline empty.
  task automatic settle();
    while (pixel_queue.size() != 0 || start || frame_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CENTER_X:     ap_center_x = val;
      CFG_CENTER_Y:     ap_center_y = val;
      CFG_RADIUS:       ap_radius = val;
      CFG_IMAGE_WIDTH:  ap_width = val[DIM_BITS-1:0];
      CFG_IMAGE_HEIGHT: ap_height = val[DIM_BITS-1:0];
      default: ;
    endcase
  endtask

  // New aperture settings, written only once the block is idle. A write to an
  // unused index follows; the block must drop it.
  task automatic apply_setup(input int cx, input int cy, input int rad,
                             input int w, input int h);
    settle();
    write_reg(CFG_CENTER_X, CFG_BITS'(cx));
    write_reg(CFG_CENTER_Y, CFG_BITS'(cy));
    write_reg(CFG_RADIUS, CFG_BITS'(rad));
    write_reg(CFG_IMAGE_WIDTH, CFG_BITS'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_BITS'(h));
    write_reg(IDX_BITS'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), CFG_BITS'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int w;
    int h;
    int rad;
    int cx;
    int cy;
    int lim;
    int pushed;
    int frame_len;
    logic close_frame;

    ap_center_x = '0;
    ap_center_y = '0;
    ap_radius = '0;
    ap_width = DIM_RESET;
    ap_height = DIM_RESET;
    flux_acc = '0;
    count_acc = '0;
    err_sq_acc = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a zero radius centered on the origin, so only the
    // pixel exactly at the center counts. Value and error extremes go in.
    pixel_queue.push_back(make_pixel(0, 0, 8388607, 65535, 1'b0));
    pixel_queue.push_back(make_pixel(1, 0, -1, 1, 1'b0));
    pixel_queue.push_back(make_pixel(4095, 4095, -8388608, 0, 1'b1));

    // Center at column 10.5, row 20, radius 3: pixels just inside, just
    // outside, and one half a pixel past the rim.
    apply_setup((10 << FRAC_BITS) | 128, 20 << FRAC_BITS, 3 << FRAC_BITS, 100, 50);
    pixel_queue.push_back(make_pixel(10, 20, -8388608, 65535, 1'b0));
    pixel_queue.push_back(make_pixel(13, 20, 5, 3, 1'b0));
    pixel_queue.push_back(make_pixel(7, 20, 7, 4, 1'b0));
    pixel_queue.push_back(make_pixel(10, 23, 9, 0, 1'b0));
    pixel_queue.push_back(make_pixel(10, 20, 1, 1, 1'b1));

    // Zero image width: the huge circle would take everything, but no pixel
    // is inside the image.
    apply_setup(0, 0, 20'hFFFFF, 0, 4096);
    pixel_queue.push_back(make_pixel(0, 0, 100, 100, 1'b0));
    pixel_queue.push_back(make_pixel(4095, 4095, 100, 100, 1'b1));

    // Width and height above the coordinate range, all settings at maximum.
    apply_setup(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 8191, 8191);
    pixel_queue.push_back(make_pixel(4095, 4095, 8388607, 65535, 1'b0));
    pixel_queue.push_back(make_pixel(0, 0, -8388608, 65535, 1'b0));
    pixel_queue.push_back(make_pixel(2048, 2048, 12345, 777, 1'b0));
    pixel_queue.push_back(make_pixel(4095, 0, 3, 2, 1'b1));

    // One-pixel image: neighbors inside the circle are cut by the image edge.
    apply_setup(0, 0, 2 << FRAC_BITS, 1, 1);
    pixel_queue.push_back(make_pixel(0, 0, -5, 9, 1'b0));
    pixel_queue.push_back(make_pixel(1, 0, 50, 9, 1'b0));
    pixel_queue.push_back(make_pixel(0, 1, 50, 9, 1'b0));
    pixel_queue.push_back(make_pixel(0, 0, 6, 10, 1'b1));

    // Zero image height.
    apply_setup(0, 0, 20'hFFFFF, 4096, 0);
    pixel_queue.push_back(make_pixel(0, 0, 42, 42, 1'b1));

    // Random phases. Each phase draws new settings, with the extremes mixed
    // in, then streams frames of random length. Most frames close with a
    // last pixel; some run on into the next frame unclosed.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 7))
        0: w = 0;
        1: w = $urandom_range(4097, 8191);
        2: w = 4096;
        default: w = $urandom_range(1, 4096);
      endcase
      case ($urandom_range(0, 7))
        0: h = 0;
        1: h = $urandom_range(4097, 8191);
        2: h = 4096;
        default: h = $urandom_range(1, 4096);
      endcase
      case ($urandom_range(0, 9))
        0: rad = 0;
        1: rad = 20'hFFFFF;
        default: rad = $urandom_range(0, 40 << FRAC_BITS);
      endcase
      lim = ((w > 4096) ? 4096 : w) << FRAC_BITS;
      cx = (lim == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF)
                                                   : $urandom_range(0, lim - 1);
      lim = ((h > 4096) ? 4096 : h) << FRAC_BITS;
      cy = (lim == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(0, 20'hFFFFF)
                                                   : $urandom_range(0, lim - 1);
      apply_setup(cx, cy, rad, w, h);

      pushed = 0;
      while (pushed < ITEMS_PER_PHASE) begin
        frame_len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 40);
        close_frame = ($urandom_range(0, 9) != 0);
        for (int k = 0; k < frame_len; k++) begin
          pixel_queue.push_back(random_pixel(close_frame && (k == frame_len - 1)));
        end
        pushed += frame_len;
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("circular_aperture_flux_with_error verification clean");
    end else begin
      $display("circular_aperture_flux_with_error verification failed");
    end
    $finish;
  end

endmodule
